// ===== src/lcrc_pkg.sv =====
// package for the letter-count run-length codec
// codes, constants, job descriptor and sequencer state type; no dependencies
package lcrc_pkg;

  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  localparam logic [AddrW-3:0] RegDirection = 1'b0;

  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;

  localparam logic [7:0] LetterA = 8'h41;
  localparam logic [7:0] LetterZ = 8'h5A;
  localparam logic [7:0] MarkQ   = 8'h51;
  localparam logic [4:0] MaxRun  = 5'd26;

  localparam logic [1:0] PhaseMark   = 2'd0;
  localparam logic [1:0] PhaseLetter = 2'd1;
  localparam logic [1:0] PhaseData   = 2'd2;

  typedef enum logic [1:0] {
    SeqIdle,
    SeqTriple,
    SeqCopy
  } seq_state_e;

  typedef struct packed {
    logic       start_triple;
    logic       start_copy;
    logic       two;
    logic [7:0] letter0;
    logic [7:0] byte0;
    logic [7:0] letter1;
    logic [7:0] byte1;
    logic [4:0] count;
    logic       last;
  } job_t;

  function automatic logic [7:0] len_to_letter(input logic [4:0] len);
    logic [7:0] sum;
    sum = LetterA + {3'b000, len} - 8'd1;
    return sum;
  endfunction

endpackage

// ===== src/lcrc_seq.sv =====
// output sequencer: steps through triples or copies one byte per cycle
// if not stalled, with index and down counters; depends on lcrc_pkg
module lcrc_seq import lcrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_load_i,
  input  job_t       job_i,
  output logic       busy_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       item_done_o,
  output logic       stream_done_o
);

  seq_state_e state_q, state_d;
  logic [1:0] idx_q, idx_d;
  logic       sel_q, sel_d;
  logic [4:0] cnt_q, cnt_d;
  logic [7:0] letter_q [2];
  logic [7:0] byte_q [2];
  logic       two_q;
  logic       last_q;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       item_done_q;
  logic       stream_done_q;

  logic       emit;
  logic [7:0] emit_byte;
  logic       emit_done;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SeqIdle: begin
        if (job_load_i && job_i.start_triple) begin
          state_d = SeqTriple;
        end else if (job_load_i && job_i.start_copy) begin
          state_d = SeqCopy;
        end
      end
      SeqTriple, SeqCopy: begin
        if (emit && emit_done) begin
          state_d = SeqIdle;
        end
      end
      default: state_d = SeqIdle;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    emit      = 1'b0;
    emit_byte = byte_q[0];
    emit_done = 1'b0;
    unique case (state_q)
      SeqTriple: begin
        emit = !out_valid_q || out_ready_i;
        case (idx_q)
          2'd0:    emit_byte = MarkQ;
          2'd1:    emit_byte = letter_q[sel_q];
          default: emit_byte = byte_q[sel_q];
        endcase
        emit_done = (idx_q == 2'd2) && (sel_q || !two_q);
      end
      SeqCopy: begin
        emit      = !out_valid_q || out_ready_i;
        emit_byte = byte_q[0];
        emit_done = (cnt_q == 5'd1);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    sel_d = sel_q;
    cnt_d = cnt_q;
    if (job_load_i && state_q == SeqIdle) begin
      idx_d = 2'd0;
      sel_d = 1'b0;
      cnt_d = job_i.count;
    end else if (emit && state_q == SeqTriple) begin
      if (idx_q == 2'd2) begin
        idx_d = 2'd0;
        sel_d = 1'b1;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end else if (emit && state_q == SeqCopy) begin
      cnt_d = cnt_q - 5'd1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SeqIdle;
      idx_q       <= 2'd0;
      sel_q       <= 1'b0;
      cnt_q       <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      sel_q       <= sel_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load_i && state_q == SeqIdle) begin
      letter_q[0] <= job_i.letter0;
      letter_q[1] <= job_i.letter1;
      byte_q[0]   <= job_i.byte0;
      byte_q[1]   <= job_i.byte1;
      two_q       <= job_i.two;
      last_q      <= job_i.last;
    end
    if (emit) begin
      out_byte_q    <= emit_byte;
      item_done_q   <= emit_done;
      stream_done_q <= emit_done && last_q;
    end
  end

  assign busy_o        = (state_q != SeqIdle);
  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign item_done_o   = item_done_q;
  assign stream_done_o = stream_done_q;

endmodule

// ===== src/letter_count_rle_codec.sv =====
// letter-count run-length codec top level: config port, run and triple state
// depends on lcrc_pkg and lcrc_seq
// output: the sequencer takes the job and then registers each output byte
// input: no new item is taken while the sequencer is busy; the k output
// bytes of an item (k is 0, 3 or 6 when encoding, 0 to 26 when decoding)
// are emitted one byte per cycle by the sequencer, unless the output stalls
// reset: asynchronous, clears direction, run and triple state and the sequencer
module letter_count_rle_codec import lcrc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             in_last_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             item_done_o,
  output logic             stream_done_o
);

  logic       direction_q;
  logic [7:0] run_byte_q, run_byte_d;
  logic [4:0] run_length_q, run_length_d;
  logic       run_open_q, run_open_d;
  logic [1:0] phase_q, phase_d;
  logic [4:0] copy_count_q, copy_count_d;

  logic       busy;
  logic       accept;
  logic       cfg_write;
  logic       reg_hit;
  job_t       job;

  logic       e0_vld;
  logic [4:0] e0_len;
  logic [7:0] e0_byte;
  logic [4:0] letter_count;

  assign pready    = 1'b1;
  assign reg_hit   = (paddr[AddrW-1:2] == RegDirection);
  assign cfg_write = psel && penable && pwrite && reg_hit;
  assign prdata    = reg_hit ? {{(DataW-1){1'b0}}, direction_q} : '0;

  assign in_ready_o = !busy;
  assign accept     = in_valid_i && in_ready_o;

  // encoder run tracking
  always_comb begin
    e0_vld       = 1'b0;
    e0_len       = run_length_q;
    e0_byte      = run_byte_q;
    run_byte_d   = run_byte_q;
    run_length_d = run_length_q;
    run_open_d   = run_open_q;
    if (!run_open_q) begin
      run_byte_d   = in_byte_i;
      run_length_d = 5'd1;
      run_open_d   = 1'b1;
    end else if (in_byte_i == run_byte_q) begin
      if (run_length_q >= MaxRun) begin
        e0_vld       = 1'b1;
        e0_len       = MaxRun;
        run_length_d = 5'd1;
      end else begin
        run_length_d = run_length_q + 5'd1;
      end
    end else begin
      e0_vld       = 1'b1;
      run_byte_d   = in_byte_i;
      run_length_d = 5'd1;
    end
  end

  // decoder letter and phase
  always_comb begin
    if (in_byte_i < LetterA) begin
      letter_count = 5'd0;
    end else if (in_byte_i > LetterZ) begin
      letter_count = MaxRun;
    end else begin
      letter_count = 5'(in_byte_i - LetterA + 8'd1);
    end
  end

  always_comb begin
    copy_count_d = copy_count_q;
    case (phase_q)
      PhaseLetter: begin
        copy_count_d = letter_count;
        phase_d      = PhaseData;
      end
      PhaseData: phase_d = PhaseMark;
      default:   phase_d = PhaseLetter;
    endcase
    if (in_last_i) begin
      phase_d = PhaseMark;
    end
  end

  always_comb begin
    job = '0;
    job.last  = in_last_i;
    job.count = copy_count_q;
    if (direction_q == DirEncode) begin
      job.start_triple = accept && (e0_vld || in_last_i);
      job.two          = e0_vld && in_last_i;
      job.letter1      = len_to_letter(run_length_d);
      job.byte1        = run_byte_d;
      if (e0_vld) begin
        job.letter0 = len_to_letter(e0_len);
        job.byte0   = e0_byte;
      end else begin
        job.letter0 = len_to_letter(run_length_d);
        job.byte0   = run_byte_d;
      end
    end else begin
      job.byte0      = in_byte_i;
      job.start_copy = accept && (phase_q == PhaseData) && (copy_count_q != 5'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q  <= DirEncode;
      run_byte_q   <= 8'd0;
      run_length_q <= 5'd0;
      run_open_q   <= 1'b0;
      phase_q      <= PhaseMark;
      copy_count_q <= 5'd0;
    end else begin
      if (cfg_write) begin
        direction_q <= pwdata[0];
      end
      if (accept && direction_q == DirEncode) begin
        run_byte_q <= run_byte_d;
        if (in_last_i) begin
          run_length_q <= 5'd0;
          run_open_q   <= 1'b0;
        end else begin
          run_length_q <= run_length_d;
          run_open_q   <= run_open_d;
        end
      end
      if (accept && direction_q == DirDecode) begin
        phase_q      <= phase_d;
        copy_count_q <= copy_count_d;
      end
    end
  end

  lcrc_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_load_i    (accept),
    .job_i         (job),
    .busy_o        (busy),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .item_done_o   (item_done_o),
    .stream_done_o (stream_done_o)
  );

endmodule

// ===== bench/tb_letter_count_rle_codec.sv =====
// testbench for letter_count_rle_codec: directed and random byte strings in both
// directions, results checked against an in-bench run-length predictor
// depends on lcrc_pkg and the letter_count_rle_codec rtl
module tb_letter_count_rle_codec;
  import lcrc_pkg::*;

  localparam int unsigned RandItems    = 380;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned CycleLimit   = 500000;
  localparam logic [AddrW-1:0] DirAddr = {RegDirection, 2'b00};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       drain;
  } src_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       item_done;
    logic       stream_done;
  } coded_t;

  typedef enum int {RdyAlways, RdyCoin, RdyThird, RdyBursty} rdy_mode_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [7:0]       in_byte_i = 8'h00;
  logic             in_last_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [7:0]       out_byte_o;
  logic             item_done_o;
  logic             stream_done_o;

  // predictor state
  logic       dir_q = DirEncode;
  logic [7:0] run_byte = 8'h00;
  logic [4:0] run_len = 5'd0;
  logic       run_open = 1'b0;
  logic [1:0] tri_phase = PhaseMark;
  logic [4:0] copy_cnt = 5'd0;

  src_item_t  src_q[$];
  coded_t     coded_q[$];
  logic [7:0] step_bytes[$];
  coded_t     head;

  int        errors = 0;
  int        queued = 0;
  int        cyc = 0;
  int        gap_left = 0;
  int        burst_left = 0;
  int        mode_left = 0;
  int        hold_left = 0;
  rdy_mode_e stall_mode = RdyAlways;
  logic      in_taken = 1'b0;

  letter_count_rle_codec uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .in_last_i     (in_last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .item_done_o   (item_done_o),
    .stream_done_o (stream_done_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cyc, msg);
    errors++;
  endtask

  task automatic emit_triple(input logic [4:0] len, input logic [7:0] b);
    logic [7:0] letter;
    letter = LetterA + {3'b000, len} - 8'd1;
    step_bytes = {step_bytes, MarkQ};
    step_bytes = {step_bytes, letter};
    step_bytes = {step_bytes, b};
  endtask

  task automatic rle_step(input logic [7:0] b, input logic last);
    coded_t     rec;
    logic [7:0] diff;
    step_bytes.delete();
    if (dir_q == DirEncode) begin
      if (!run_open) begin
        run_byte = b;
        run_len  = 5'd1;
        run_open = 1'b1;
      end else if (b == run_byte) begin
        if (run_len >= MaxRun) begin
          emit_triple(MaxRun, run_byte);
          run_len = 5'd1;
        end else begin
          run_len = run_len + 5'd1;
        end
      end else begin
        emit_triple(run_len, run_byte);
        run_byte = b;
        run_len  = 5'd1;
      end
      if (last) begin
        emit_triple(run_len, run_byte);
        run_open = 1'b0;
        run_len  = 5'd0;
      end
    end else begin
      case (tri_phase)
        PhaseLetter: begin
          diff = b - LetterA + 8'd1;
          if (b < LetterA) copy_cnt = 5'd0;
          else if (b > LetterZ) copy_cnt = MaxRun;
          else copy_cnt = diff[4:0];
          tri_phase = PhaseData;
        end
        PhaseData: begin
          for (int i = 0; i < copy_cnt; i++) step_bytes = {step_bytes, b};
          tri_phase = PhaseMark;
        end
        default: begin
          tri_phase = PhaseLetter;
        end
      endcase
      if (last) tri_phase = PhaseMark;
    end
    foreach (step_bytes[k]) begin
      rec.data        = step_bytes[k];
      rec.item_done   = (k == step_bytes.size() - 1);
      rec.stream_done = rec.item_done && last;
      coded_q = {coded_q, rec};
    end
  endtask

  task automatic push_item(input logic [7:0] b, input logic last, input logic drain);
    src_item_t it;
    it.data  = b;
    it.last  = last;
    it.drain = drain;
    src_q = {src_q, it};
    queued++;
  endtask

  task automatic write_direction(input logic d);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DirAddr;
    pwdata  <= {{(DataW-1){1'b0}}, d};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    dir_q = d;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {{(DataW-1){1'b0}}, d})
      report($sformatf("direction readback %h, wrote %b", prdata, d));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    while (src_q.size() != 0 || in_valid_i || coded_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic gen_encode(input int n);
    int         cnt;
    int         len;
    int         sel;
    logic [7:0] b;
    logic       end_str;
    cnt = 0;
    while (cnt < n) begin
      sel = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom_range(0, 255));
      endcase
      if (sel < 6) len = $urandom_range(1, 4);
      else if (sel < 9) len = $urandom_range(5, 26);
      else len = $urandom_range(25, 60);
      end_str = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < len; j++)
        push_item(b, end_str && (j == len - 1), $urandom_range(0, 99) == 0);
      cnt += len;
    end
  endtask

  task automatic gen_decode(input int n);
    int         cnt;
    int         sel;
    logic [7:0] mark;
    logic [7:0] letter;
    logic [7:0] data;
    logic       fin;
    cnt = 0;
    while (cnt < n) begin
      sel    = $urandom_range(0, 9);
      mark   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : MarkQ;
      letter = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                           : LetterA + 8'($urandom_range(0, 25));
      data   = 8'($urandom_range(0, 255));
      if (sel < 7) begin
        fin = ($urandom_range(0, 4) == 0);
        push_item(mark, 1'b0, $urandom_range(0, 99) == 0);
        push_item(letter, 1'b0, 1'b0);
        push_item(data, fin, 1'b0);
        cnt += 3;
      end else if (sel == 7) begin
        push_item(mark, 1'b0, 1'b0);
        push_item(letter, 1'b1, 1'b0);
        cnt += 2;
      end else if (sel == 8) begin
        push_item(mark, 1'b1, 1'b0);
        cnt += 1;
      end else begin
        push_item(data, 1'($urandom_range(0, 1)), 1'b0);
        cnt += 1;
      end
    end
  endtask

  // input driver
  always @(negedge clk_i) begin
    src_item_t nxt;
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (src_q.size() != 0 && !(src_q[0].drain && coded_q.size() != 0)) begin
        nxt = src_q.pop_front();
        in_valid_i <= 1'b1;
        in_byte_i  <= nxt.data;
        in_last_i  <= nxt.last;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output ready pattern
  always @(negedge clk_i) begin
    logic rdy;
    if (mode_left == 0) begin
      stall_mode = rdy_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 150);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      RdyAlways: rdy = 1'b1;
      RdyCoin:   rdy = 1'($urandom_range(0, 1));
      RdyThird:  rdy = (cyc % 3 == 0);
      default: begin
        if (hold_left > 0) begin
          hold_left--;
          rdy = 1'b0;
        end else begin
          rdy       = 1'b1;
          hold_left = $urandom_range(0, 8);
        end
      end
    endcase
    out_ready_i <= rdy;
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        if (coded_q.size() == 0) begin
          report($sformatf("output transfer %h with nothing expected", out_byte_o));
        end else begin
          head = coded_q.pop_front();
          if (out_byte_o !== head.data)
            report($sformatf("out_byte %h, expected %h", out_byte_o, head.data));
          if (item_done_o !== head.item_done)
            report($sformatf("item_done %b, expected %b", item_done_o, head.item_done));
          if (stream_done_o !== head.stream_done)
            report($sformatf("stream_done %b, expected %b", stream_done_o, head.stream_done));
        end
      end
      if (in_valid_i && in_ready_o) rle_step(in_byte_i, in_last_i);
    end
  end

  always @(posedge clk_i) begin
    cyc++;
    if (cyc > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic dir;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed encode: single byte string, pair then new byte
    write_direction(DirEncode);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hFF, 1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b0);
    push_item(8'h5A, 1'b1, 1'b0);
    wait_idle();

    // directed decode: extremes, letters below and above range, dropped triple
    write_direction(DirDecode);
    push_item(MarkQ, 1'b0, 1'b0);
    push_item(LetterA, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(MarkQ, 1'b0, 1'b0);
    push_item(LetterZ, 1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b0);
    push_item(MarkQ, 1'b0, 1'b0);
    push_item(8'h40, 1'b0, 1'b0);
    push_item(8'h11, 1'b0, 1'b0);
    push_item(MarkQ, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'h22, 1'b0, 1'b0);
    push_item(MarkQ, 1'b0, 1'b1);
    push_item(8'h5B, 1'b0, 1'b0);
    push_item(8'h33, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b0);
    push_item(8'h44, 1'b1, 1'b0);
    push_item(MarkQ, 1'b0, 1'b0);
    push_item(8'h43, 1'b1, 1'b0);
    wait_idle();

    queued = 0;
    dir = DirDecode;
    while (queued < RandItems) begin
      dir = !dir;
      write_direction(dir);
      if (dir == DirEncode) gen_encode($urandom_range(30, 80));
      else gen_decode($urandom_range(30, 80));
      wait_idle();
    end

    wait_idle();
    if (errors == 0 && coded_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
